@@ rtl/core/ctss_pkg.sv @@
// Shared types and constants for the seven-segment clock frame serializer.
package ctss_pkg;

    localparam int FrameBytes = 6;
    localparam int FrameBits  = FrameBytes * 8;
    localparam int IndexW     = $clog2(FrameBits);

    localparam logic [IndexW-1:0] LastIndex = IndexW'(FrameBits - 1);

    // One frame of segment bytes, hour tens byte in the top byte, 1 = lit
    typedef logic [FrameBits-1:0] frame_t;

endpackage

@@ rtl/core/ctss_front.sv @@
// Front stage: clamp the time, convert to 12-hour form, split digits and encode the segment frame.
module ctss_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [5:0]      seconds,
    input  logic [5:0]      minutes,
    input  logic [4:0]      hours,
    output logic            frame_valid,
    input  logic            frame_ready,
    output ctss_pkg::frame_t frame
);
    import ctss_pkg::*;

    localparam logic [7:0] SegA  = 8'h08;
    localparam logic [7:0] SegB  = 8'h04;
    localparam logic [7:0] SegC  = 8'h02;
    localparam logic [7:0] SegD  = 8'h20;
    localparam logic [7:0] SegE  = 8'h80;
    localparam logic [7:0] SegF  = 8'h40;
    localparam logic [7:0] SegG  = 8'h10;
    localparam logic [7:0] SegDp = 8'h01;

    localparam logic [5:0] MaxMinSec = 6'd59;
    localparam logic [4:0] MaxHour   = 5'd23;
    localparam logic [4:0] HalfDay   = 5'd12;
    localparam logic [4:0] Ten       = 5'd10;

    function automatic logic [7:0] glyph(input logic [3:0] d);
        logic [7:0] g;
        begin
            case (d)
                4'd0:    g = SegA | SegB | SegC | SegD | SegE | SegF;
                4'd1:    g = SegB | SegC;
                4'd2:    g = SegA | SegB | SegD | SegE | SegG;
                4'd3:    g = SegA | SegB | SegC | SegD | SegG;
                4'd4:    g = SegB | SegC | SegF | SegG;
                4'd5:    g = SegA | SegC | SegD | SegF | SegG;
                4'd6:    g = SegA | SegC | SegD | SegE | SegF | SegG;
                4'd7:    g = SegA | SegB | SegC;
                4'd8:    g = SegA | SegB | SegC | SegD | SegE | SegF | SegG;
                4'd9:    g = SegA | SegB | SegC | SegD | SegF | SegG;
                default: g = 8'h00;
            endcase
            return g;
        end
    endfunction

    // Tens digit of a value 0..59 by range compare
    function automatic logic [2:0] tens_of(input logic [5:0] v);
        logic [2:0] t;
        begin
            if (v >= 6'd50)      t = 3'd5;
            else if (v >= 6'd40) t = 3'd4;
            else if (v >= 6'd30) t = 3'd3;
            else if (v >= 6'd20) t = 3'd2;
            else if (v >= 6'd10) t = 3'd1;
            else                 t = 3'd0;
            return t;
        end
    endfunction

    logic [5:0] sec_c, min_c;
    logic [4:0] hr24_c, hr12, hr_ones;
    logic [2:0] sec_tens, min_tens;
    logic [5:0] sec_ones, min_ones;
    logic       is_am, hr_two_digit;
    frame_t     frame_c;
    frame_t     frame_reg;
    logic       valid_reg;

    // Clamp, convert to 12-hour form and split digits
    always_comb
    begin
        sec_c    = (seconds > MaxMinSec) ? MaxMinSec : seconds;
        min_c    = (minutes > MaxMinSec) ? MaxMinSec : minutes;
        hr24_c   = (hours > MaxHour) ? MaxHour : hours;
        is_am    = hr24_c < HalfDay;
        hr12     = is_am ? hr24_c : (hr24_c - HalfDay);
        if (hr12 == 5'd0)
        begin
            hr12 = HalfDay;
        end
        hr_two_digit = hr12 >= Ten;
        hr_ones      = hr_two_digit ? (hr12 - Ten) : hr12;
        sec_tens     = tens_of(sec_c);
        min_tens     = tens_of(min_c);
        sec_ones     = sec_c - 6'({3'd0, sec_tens} * 6'd10);
        min_ones     = min_c - 6'({3'd0, min_tens} * 6'd10);

        frame_c[47:40] = (hr_two_digit ? glyph(4'd1) : 8'h00) | (is_am ? SegDp : 8'h00);
        frame_c[39:32] = glyph(hr_ones[3:0]) | (is_am ? 8'h00 : SegDp);
        frame_c[31:24] = glyph({1'b0, min_tens}) | SegDp;
        frame_c[23:16] = glyph(min_ones[3:0]) | SegDp;
        frame_c[15:8]  = glyph({1'b0, sec_tens});
        frame_c[7:0]   = glyph(sec_ones[3:0]);
    end

    assign in_ready    = !valid_reg || frame_ready;
    assign frame_valid = valid_reg;
    assign frame       = frame_reg;

    // Hold the encoded frame until the queue takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            frame_reg <= frame_c;
        end
    end

endmodule

@@ rtl/core/ctss_queue.sv @@
// Two-entry frame queue between the encoder and the serializer.
module ctss_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  ctss_pkg::frame_t push_frame,
    output logic             pop_valid,
    input  logic             pop,
    output ctss_pkg::frame_t pop_frame
);
    import ctss_pkg::*;

    frame_t     entries_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push, do_pop;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign pop_frame  = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // Write the incoming frame
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_frame;
        end
    end

endmodule

@@ rtl/core/ctss_serializer.sv @@
// Back stage: shift each frame out one active-low bit per word, MSB first.
module ctss_serializer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        frame_valid,
    output logic                        frame_pop,
    input  ctss_pkg::frame_t            frame,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        serial_bit,
    output logic [ctss_pkg::IndexW-1:0] bit_index,
    output logic                        last
);
    import ctss_pkg::*;

    frame_t            shift_reg;
    logic [IndexW-1:0] idx_reg;
    logic              busy_reg;
    logic              out_valid_reg, serial_bit_reg, last_reg;
    logic [IndexW-1:0] bit_index_reg;
    logic              advance, at_end;

    assign advance   = !out_valid_reg || out_ready;
    assign at_end    = idx_reg == LastIndex;
    assign frame_pop = frame_valid && (!busy_reg || (advance && at_end));

    assign out_valid  = out_valid_reg;
    assign serial_bit = serial_bit_reg;
    assign bit_index  = bit_index_reg;
    assign last       = last_reg;

    // Control: busy flag, bit counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= busy_reg;
            end
            if (busy_reg && advance)
            begin
                if (at_end)
                begin
                    busy_reg <= frame_pop;
                    idx_reg  <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + IndexW'(1);
                end
            end
            else if (frame_pop)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
        end
    end

    // Payload: shift line and output word
    always_ff @(posedge clk)
    begin
        if (busy_reg && advance)
        begin
            serial_bit_reg <= !shift_reg[FrameBits-1];
            bit_index_reg  <= idx_reg;
            last_reg       <= at_end;
        end
        if (frame_pop)
        begin
            shift_reg <= frame;
        end
        else if (busy_reg && advance)
        begin
            shift_reg <= {shift_reg[FrameBits-2:0], 1'b0};
        end
    end

endmodule

@@ rtl/core/clock_time_seven_segment_shifter.sv @@
// Top level of the seven-segment clock frame serializer.
//
// Input channel (in_valid/in_ready): one time of day per word, as seconds,
// minutes and 24-hour hours in binary; values above range clamp to maximum.
// Output channel (out_valid/out_ready): 48 words per time, each carrying one
// active-low segment bit, its frame position and a last flag on bit 47.
// Bytes go hour tens first to second ones last, MSB first.
//
// With the serializer idle, an accepted time passes the encoder register, a
// queue entry, the shift line and the output register. Output is one bit per
// cycle while out_ready holds high, set by the single-bit output port.
// The encoder and a two-frame queue take new times while a frame shifts out.
// A stall on out_ready holds the current bit and freezes the shift line;
// times back up into the queue and then in_ready drops.
// Reset clears all valid flags, counters and queue pointers; no frame is
// in flight afterwards.
module clock_time_seven_segment_shifter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [5:0]                  seconds,
    input  logic [5:0]                  minutes,
    input  logic [4:0]                  hours,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        serial_bit,
    output logic [ctss_pkg::IndexW-1:0] bit_index,
    output logic                        last
);
    import ctss_pkg::*;

    frame_t enc_frame, q_frame;
    logic   enc_valid, enc_ready, q_valid, q_pop;

    ctss_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .seconds     (seconds),
        .minutes     (minutes),
        .hours       (hours),
        .frame_valid (enc_valid),
        .frame_ready (enc_ready),
        .frame       (enc_frame)
    );

    ctss_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (enc_valid),
        .push_ready (enc_ready),
        .push_frame (enc_frame),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_frame  (q_frame)
    );

    ctss_serializer u_serializer (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (q_valid),
        .frame_pop   (q_pop),
        .frame       (q_frame),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .serial_bit  (serial_bit),
        .bit_index   (bit_index),
        .last        (last)
    );

endmodule
